// ----- rtl/tla_pkg.sv -----
// ----------------------------------------------------------------------------
// tla_pkg
// Shared types and byte codes of the terminal line assembler.
// ----------------------------------------------------------------------------
package tla_pkg;

    localparam logic [7:0] ESC_BYTE   = 8'h1B;
    localparam logic [7:0] CSI_BYTE   = 8'h5B;
    localparam logic [7:0] LF_BYTE    = 8'h0A;
    localparam logic [7:0] BS_BYTE    = 8'h08;
    localparam logic [7:0] DEL_BYTE   = 8'h7F;
    localparam logic [7:0] TAB_BYTE   = 8'h09;
    localparam logic [7:0] PRINT_LO   = 8'h20;
    localparam logic [7:0] PRINT_HI   = 8'h7E;
    localparam logic [7:0] FINAL_LO   = 8'h40;
    localparam logic [7:0] FINAL_HI   = 8'h7E;
    localparam logic [6:0] SPACE_CHAR = 7'h20;
    localparam logic [5:0] ESC_LIMIT  = 6'd32;

    // what a byte does outside of the escape bookkeeping
    typedef enum logic [2:0] {
        CLS_SWALLOW,
        CLS_LF,
        CLS_ERASE,
        CLS_TAB,
        CLS_PRINT,
        CLS_IGNORE
    } t_byte_class;

    typedef struct packed {
        logic take;
        logic append_byte;
        logic append_space;
        logic backspace;
        logic load_empty;
        logic fetch;
        logic advance;
        logic clear_line;
    } t_dp_cmd;

    typedef struct packed {
        t_byte_class byte_class;
        logic        len_zero;
        logic        tab_done;
        logic        out_last;
    } t_dp_status;

endpackage

// ----- rtl/tla_if.sv -----
// ----------------------------------------------------------------------------
// tla_if
// Valid/ready channels of the line assembler: raw bytes in, line words out.
// ----------------------------------------------------------------------------
interface tla_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface tla_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] line_char;
    logic       char_present;
    logic       line_last;

    modport source (output valid, output line_char, output char_present,
                    output line_last, input ready);
    modport sink   (input valid, input line_char, input char_present,
                    input line_last, output ready);
endinterface

// ----- rtl/terminal_line_assembler.sv -----
// ----------------------------------------------------------------------------
// terminal_line_assembler
// Builds text lines from raw serial bytes, swallowing escape sequences, and
// streams each finished line out on a line feed.
//
//   channel   dir  payload                              accepted when
//   i_byte    in   data_byte[7:0]                       valid && ready
//   o_char    out  line_char[6:0] char_present line_last  valid && ready
//
// A tab pads the line with spaces up to the next stop, ending early once the
// line is full (at least one padding step). A line feed streams the line out
// character by character through the single registered read port of the line
// store, fetching and then offering each one (an empty line sends one empty
// word), while the sink may hold ready low; no byte is taken
// meanwhile. Synchronous active-low reset empties the line and ends any escape.
// ----------------------------------------------------------------------------
module terminal_line_assembler
    import tla_pkg::*;
#(
    parameter int LINE_CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tla_byte_if.sink   i_byte,
    tla_char_if.source o_char
);

    t_dp_cmd    cmd;
    t_dp_status status;

    tla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_byte.valid),
        .o_in_ready  (i_byte.ready),
        .o_out_valid (o_char.valid),
        .i_out_ready (o_char.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tla_datapath #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_data_byte    (i_byte.data_byte),
        .o_status       (status),
        .o_line_char    (o_char.line_char),
        .o_char_present (o_char.char_present),
        .o_line_last    (o_char.line_last)
    );

endmodule

// ----- rtl/tla_datapath.sv -----
// ----------------------------------------------------------------------------
// tla_datapath
// Line store, length, escape tracking, byte classification and output word.
// ----------------------------------------------------------------------------
module tla_datapath
    import tla_pkg::*;
#(
    parameter int LINE_CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [7:0] i_data_byte,
    output t_dp_status o_status,
    output logic [6:0] o_line_char,
    output logic       o_char_present,
    output logic       o_line_last
);

    localparam int IDX_W = $clog2(LINE_CAPACITY);
    localparam int LEN_W = $clog2(LINE_CAPACITY + 1);
    localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_CAPACITY);

    logic [6:0]       r_mem [LINE_CAPACITY];
    logic [LEN_W-1:0] r_len, n_len;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_in_esc, n_in_esc;
    logic [5:0]       r_esc_cnt, n_esc_cnt;
    logic             r_esc_csi, n_esc_csi;
    logic [6:0]       r_char;
    logic             r_present;
    logic             r_last;

    logic             full;
    logic             wr_en;
    logic [6:0]       wr_data;
    logic             esc_end;
    t_byte_class      byte_class;

    assign full = (r_len >= CAP);

    always_comb begin
        if (r_in_esc || i_data_byte == ESC_BYTE) begin
            byte_class = CLS_SWALLOW;
        end else if (i_data_byte == LF_BYTE) begin
            byte_class = CLS_LF;
        end else if (i_data_byte == BS_BYTE || i_data_byte == DEL_BYTE) begin
            byte_class = CLS_ERASE;
        end else if (i_data_byte == TAB_BYTE) begin
            byte_class = CLS_TAB;
        end else if (i_data_byte inside {[PRINT_LO:PRINT_HI]}) begin
            byte_class = CLS_PRINT;
        end else begin
            byte_class = CLS_IGNORE;
        end
    end

    // escape bookkeeping, updated on every taken byte
    always_comb begin
        n_in_esc  = r_in_esc;
        n_esc_cnt = r_esc_cnt;
        n_esc_csi = r_esc_csi;
        esc_end   = 1'b0;
        if (i_cmd.take) begin
            if (r_in_esc) begin
                n_esc_cnt = r_esc_cnt + 6'd1;
                if (n_esc_cnt == 6'd2) begin
                    n_esc_csi = (i_data_byte == CSI_BYTE);
                end
                if (n_esc_csi) begin
                    if (n_esc_cnt > 6'd2 && i_data_byte inside {[FINAL_LO:FINAL_HI]}) begin
                        esc_end = 1'b1;
                    end
                end else begin
                    esc_end = 1'b1;
                end
                // overlong escape is abandoned
                if (n_esc_cnt > ESC_LIMIT) begin
                    esc_end = 1'b1;
                end
                if (esc_end) begin
                    n_in_esc  = 1'b0;
                    n_esc_cnt = 6'd0;
                    n_esc_csi = 1'b0;
                end
            end else if (i_data_byte == ESC_BYTE) begin
                n_in_esc  = 1'b1;
                n_esc_cnt = 6'd1;
                n_esc_csi = 1'b0;
            end
        end
    end

    assign wr_en   = (i_cmd.append_byte || i_cmd.append_space) && !full;
    assign wr_data = i_cmd.append_space ? SPACE_CHAR : i_data_byte[6:0];

    always_comb begin
        n_len    = r_len;
        n_rd_idx = r_rd_idx;
        if (i_cmd.clear_line) begin
            n_len    = '0;
            n_rd_idx = '0;
        end else if (i_cmd.advance) begin
            n_rd_idx = r_rd_idx + IDX_W'(1);
        end else if (wr_en) begin
            n_len = r_len + LEN_W'(1);
        end else if (i_cmd.backspace && r_len != '0) begin
            n_len = r_len - LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_rd_idx  <= '0;
            r_in_esc  <= 1'b0;
            r_esc_cnt <= '0;
            r_esc_csi <= 1'b0;
        end else begin
            r_len     <= n_len;
            r_rd_idx  <= n_rd_idx;
            r_in_esc  <= n_in_esc;
            r_esc_cnt <= n_esc_cnt;
            r_esc_csi <= n_esc_csi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_len[IDX_W-1:0]] <= wr_data;
        end
    end

    // output word register, read port of the line store
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_char    <= r_mem[r_rd_idx];
            r_present <= 1'b1;
            r_last    <= (LEN_W'(r_rd_idx) + LEN_W'(1) == r_len);
        end else if (i_cmd.load_empty) begin
            r_char    <= '0;
            r_present <= 1'b0;
            r_last    <= 1'b1;
        end
    end

    assign o_status.byte_class = byte_class;
    assign o_status.len_zero   = (r_len == '0);
    assign o_status.tab_done   = full || (r_len[1:0] == 2'd3);
    assign o_status.out_last   = r_last;

    assign o_line_char    = r_char;
    assign o_char_present = r_present;
    assign o_line_last    = r_last;

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CAP)
        else $error("line length beyond capacity");

    a_esc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc_cnt <= ESC_LIMIT && (r_in_esc || r_esc_cnt == '0))
        else $error("escape count out of range");

    a_erase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.backspace && r_len != '0 && !i_cmd.clear_line |=>
        r_len == $past(r_len) - LEN_W'(1))
        else $error("erase did not drop one character");
`endif

endmodule

// ----- rtl/tla_ctrl.sv -----
// ----------------------------------------------------------------------------
// tla_ctrl
// Sequencer of the line assembler: byte intake, tab padding, line readout.
// ----------------------------------------------------------------------------
module tla_ctrl
    import tla_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_TAB   = 4'b0010,
        S_FETCH = 4'b0100,
        S_SEND  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   take;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_SEND);
    assign take        = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.take = take;
                if (take) begin
                    case (i_status.byte_class)
                        CLS_LF: begin
                            if (i_status.len_zero) begin
                                o_cmd.load_empty = 1'b1;
                                n_state          = S_SEND;
                            end else begin
                                n_state = S_FETCH;
                            end
                        end
                        CLS_TAB:   n_state = S_TAB;
                        CLS_PRINT: o_cmd.append_byte = 1'b1;
                        CLS_ERASE: o_cmd.backspace = 1'b1;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_TAB: begin
                // one space a cycle up to the next stop or a full line
                o_cmd.append_space = 1'b1;
                if (i_status.tab_done) begin
                    n_state = S_IDLE;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_SEND;
            end
            S_SEND: begin
                if (i_out_ready) begin
                    if (i_status.out_last) begin
                        o_cmd.clear_line = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_FETCH;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("intake open while a word is offered");

    a_fetch_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FETCH |=> o_out_valid)
        else $error("fetched word not offered");

    a_next_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !i_status.out_last |=> r_state == S_FETCH)
        else $error("line readout stopped early");
`endif

endmodule

// ----- test/terminal_line_assembler_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// terminal_line_assembler_checker
// Watches both channels of the line assembler. It keeps its own copy of the
// line and escape state, queues the line words that each accepted byte
// should produce, and compares every word on the output channel against
// the oldest one queued. Mismatches and unexpected words are counted.
// ----------------------------------------------------------------------------
module terminal_line_assembler_checker
    import tla_pkg::*;
#(
    parameter int LINE_CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [6:0] i_line_char,
    input  logic       i_char_present,
    input  logic       i_line_last,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int TAB_STOP = 4;

    typedef struct packed {
        logic [6:0] ch;
        logic       present;
        logic       last;
    } t_line_word;

    logic [6:0] line_buf [LINE_CAPACITY];
    int         line_len;
    bit         esc_active;
    int         esc_cnt;
    bit         esc_csi;
    t_line_word words_due [$];

    function automatic void queue_word(input t_line_word w);
        words_due.insert(words_due.size(), w);
    endfunction

    function automatic void push_char(input logic [6:0] ch);
        if (line_len < LINE_CAPACITY) begin
            line_buf[line_len] = ch;
            line_len++;
        end
    endfunction

    // advance the line state by one byte and queue any words it releases
    function automatic void absorb_byte(input logic [7:0] c);
        int         pad;
        t_line_word w;
        if (esc_active) begin
            esc_cnt++;
            if (esc_cnt == 2)
                esc_csi = (c == CSI_BYTE);
            // a plain escape ends on its second byte, a csi on a final byte
            if (!esc_csi || (esc_cnt > 2 && c >= FINAL_LO && c <= FINAL_HI) ||
                esc_cnt > ESC_LIMIT) begin
                esc_active = 1'b0;
                esc_cnt    = 0;
                esc_csi    = 1'b0;
            end
        end else if (c == ESC_BYTE) begin
            esc_active = 1'b1;
            esc_cnt    = 1;
            esc_csi    = 1'b0;
        end else if (c == LF_BYTE) begin
            if (line_len == 0) begin
                w = '{ch: 7'd0, present: 1'b0, last: 1'b1};
                queue_word(w);
            end else begin
                for (int i = 0; i < line_len; i++) begin
                    w = '{ch: line_buf[i], present: 1'b1, last: (i == line_len - 1)};
                    queue_word(w);
                end
                line_len = 0;
            end
        end else if (c == BS_BYTE || c == DEL_BYTE) begin
            if (line_len > 0)
                line_len--;
        end else if (c == TAB_BYTE) begin
            pad = TAB_STOP - (line_len % TAB_STOP);
            repeat (pad) push_char(SPACE_CHAR);
        end else if (c >= PRINT_LO && c <= PRINT_HI) begin
            push_char(c[6:0]);
        end
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_line_word w;
        if (!i_rst_n) begin
            line_len   = 0;
            esc_active = 1'b0;
            esc_cnt    = 0;
            esc_csi    = 1'b0;
            words_due.delete();
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                absorb_byte(i_in_byte);
            if (i_out_valid && i_out_ready) begin
                if (words_due.size() == 0) begin
                    $error("unexpected line word: line_char %0h char_present %0b line_last %0b",
                           i_line_char, i_char_present, i_line_last);
                    o_fail_count++;
                end else begin
                    w = words_due.pop_front();
                    if (i_line_char !== w.ch) begin
                        $error("line_char mismatch: expected %0h, got %0h", w.ch, i_line_char);
                        o_fail_count++;
                    end
                    if (i_char_present !== w.present) begin
                        $error("char_present mismatch: expected %0b, got %0b",
                               w.present, i_char_present);
                        o_fail_count++;
                    end
                    if (i_line_last !== w.last) begin
                        $error("line_last mismatch: expected %0b, got %0b", w.last, i_line_last);
                        o_fail_count++;
                    end
                end
            end
            o_pending <= words_due.size();
        end
    end

endmodule

// ----- test/terminal_line_assembler_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// terminal_line_assembler_tb
// Feeds raw serial bytes into the line assembler: a short directed run over
// the byte classes and corner cases, then random lines mixed with escapes,
// overflowing lines, overlong escapes, erase bursts and noise. Both channels
// stall at random. A side checker predicts and compares every line word.
// ----------------------------------------------------------------------------
module terminal_line_assembler_tb
    import tla_pkg::*;
();

    localparam int          RANDOM_ITEMS = 360;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          TIMEOUT_NS   = 2_000_000;
    localparam int          STEADY_FROM  = 120;
    localparam int          STEADY_TO    = 240;
    localparam logic [7:0]  CR_BYTE      = 8'h0D;
    localparam logic [7:0]  BEL_BYTE     = 8'h07;
    localparam logic [7:0]  CSI_PARAM_LO = 8'h30;
    localparam logic [7:0]  CSI_PARAM_HI = 8'h3F;

    logic i_clk;
    logic i_rst_n;
    bit   no_stall;
    int   items_fed;
    int   fail_count;
    int   pending;

    tla_byte_if byte_ch ();
    tla_char_if char_ch ();

    terminal_line_assembler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_char  (char_ch)
    );

    terminal_line_assembler_checker checker_0 (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (byte_ch.valid),
        .i_in_ready     (byte_ch.ready),
        .i_in_byte      (byte_ch.data_byte),
        .i_out_valid    (char_ch.valid),
        .i_out_ready    (char_ch.ready),
        .i_line_char    (char_ch.line_char),
        .i_char_present (char_ch.char_present),
        .i_line_last    (char_ch.line_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("terminal_line_assembler verification failed");
        $finish;
    end

    // sink side stalls at random except during the steady stretch
    initial begin
        char_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            char_ch.ready <= no_stall || ($urandom_range(99) >= 37);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (!no_stall) begin
            while ($urandom_range(99) < 37) begin
                byte_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        @(posedge i_clk);
        while (!byte_ch.ready)
            @(posedge i_clk);
        items_fed++;
    endtask

    // csi with a number of parameter bytes, closed by a random final byte
    task automatic send_csi(input int n_params);
        send_byte(ESC_BYTE);
        send_byte(CSI_BYTE);
        repeat (n_params) begin
            if ($urandom_range(9) == 0)
                send_byte(8'($urandom_range(CSI_PARAM_HI, 0)));
            else
                send_byte(8'($urandom_range(CSI_PARAM_HI, PRINT_LO)));
        end
        send_byte(8'($urandom_range(FINAL_HI, FINAL_LO)));
    endtask

    logic [7:0] directed_bytes [21] = '{
        LF_BYTE, BS_BYTE, PRINT_LO, PRINT_HI, 8'h41, DEL_BYTE, TAB_BYTE,
        CR_BYTE, BEL_BYTE, 8'h00, 8'hFF, 8'h80,
        ESC_BYTE, CSI_BYTE, 8'h31, CSI_PARAM_HI, 8'h6D,
        ESC_BYTE, LF_BYTE, 8'h5A, LF_BYTE
    };

    initial begin
        int seq;
        int kind;
        int r;
        int n;
        i_rst_n           <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= 8'h00;
        no_stall  = 1'b0;
        items_fed = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        seq = 0;
        while (items_fed < RANDOM_ITEMS) begin
            no_stall = (items_fed >= STEADY_FROM && items_fed < STEADY_TO);
            if (seq < 5) begin
                kind = seq;
            end else begin
                r = $urandom_range(99);
                kind = (r < 55) ? 0 : (r < 63) ? 1 : (r < 73) ? 2 : (r < 85) ? 3 : 4;
            end
            case (kind)
                0: begin
                    // ordinary line with edits, escapes and stray bytes
                    repeat ($urandom_range(12)) begin
                        r = $urandom_range(99);
                        if (r < 62)
                            send_byte(8'($urandom_range(PRINT_HI, PRINT_LO)));
                        else if (r < 70)
                            send_byte(TAB_BYTE);
                        else if (r < 78)
                            send_byte($urandom_range(1) ? BS_BYTE : DEL_BYTE);
                        else if (r < 86) begin
                            if ($urandom_range(1))
                                send_csi($urandom_range(4));
                            else begin
                                send_byte(ESC_BYTE);
                                send_byte(8'($urandom_range(8'hFF)));
                            end
                        end else if (r < 93)
                            send_byte(8'($urandom_range(8'h1F)));
                        else
                            send_byte(8'($urandom_range(8'hFF, 8'h80)));
                    end
                    send_byte(LF_BYTE);
                end
                1: begin
                    // runs near and past capacity, tabs included
                    repeat ($urandom_range(70, 56)) begin
                        if ($urandom_range(9) == 0)
                            send_byte(TAB_BYTE);
                        else
                            send_byte(8'($urandom_range(PRINT_HI, PRINT_LO)));
                    end
                    send_byte(LF_BYTE);
                end
                2: begin
                    // escape around the length limit, then text to show recovery
                    n = $urandom_range(34, 28);
                    send_csi(n);
                    repeat ($urandom_range(3))
                        send_byte(8'($urandom_range(PRINT_HI, PRINT_LO)));
                    send_byte(LF_BYTE);
                end
                3: begin
                    repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(8'hFF)));
                end
                default: begin
                    // erase bursts, often more than was typed
                    repeat ($urandom_range(3))
                        send_byte(8'($urandom_range(PRINT_HI, PRINT_LO)));
                    repeat ($urandom_range(6, 1))
                        send_byte($urandom_range(1) ? BS_BYTE : DEL_BYTE);
                    send_byte(LF_BYTE);
                end
            endcase
            seq++;
        end
        byte_ch.valid <= 1'b0;
        no_stall = 1'b0;

        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("terminal_line_assembler verification clean");
        else
            $display("terminal_line_assembler verification failed");
        $finish;
    end

endmodule
